// ----- sv/haurf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unique range finder package
// Shared types and constants for the hash anchored unique range finder.
// ----------------------------------------------------------------------------
package haurf_pkg;

  localparam int unsigned TableEntriesDef = 256;
  localparam int unsigned CountW = 16;
  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic ActCount = 1'b0;
  localparam logic ActScan  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] chunk_start;
    logic [31:0] chunk_end;
    logic [31:0] chunk_hash;
    logic        last_chunk;
  } req_t;

  typedef struct packed {
    logic        range_valid;
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic [31:0] anchor_tag;
    logic        scan_done;
    logic        table_overflow;
  } rsp_t;

endpackage

// ----- sv/hash_anchored_unique_range_finder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash anchored unique range finder
// Counts the other stream's chunk hashes, then scans our chunks and reports
// the unique ranges between common chunks.
// ----------------------------------------------------------------------------
// Usage: drive req_i and raise start; the transaction is taken at an edge
// where busy is low. Action 0 counts chunk_hash in the table, action 1
// scans one of our chunks. Every transaction yields exactly one result on
// rsp_o, marked by done_o for one cycle; the receiver cannot stall it.
// Transactions pass a two-entry queue to the table engine, which picks a
// transaction up in its idle state, probes one slot at a time from the
// home slot on (memory read, then compare) and then writes back; it takes
// no new transaction until it is back in idle. done_o is registered from
// the write step. The memory read is registered, so each probe needs a
// read step before its compare step. TableEntries must be a power of two.
// After reset, and after every 255th last scan chunk, a sweep restamps
// every slot of the table; busy stays high once the queue fills.
// A last scan chunk clears the table and the anchor for the next scan.
// ----------------------------------------------------------------------------
module hash_anchored_unique_range_finder #(
  parameter int unsigned TableEntries = haurf_pkg::TableEntriesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  haurf_pkg::req_t req_i,
  output logic            done_o,
  output haurf_pkg::rsp_t rsp_o
);

  logic            full, empty, pop, idle;
  haurf_pkg::req_t q_data;

  // Front end: accept into the queue.
  assign busy = full;

  haurf_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(start && !full), .push_data_i(req_i),
    .pop_i(pop), .full_o(full), .empty_o(empty), .pop_data_o(q_data)
  );

  haurf_engine #(.TableEntries(TableEntries)) u_engine (
    .clk_i, .rst_ni,
    .req_valid_i(!empty), .req_i(q_data), .req_pop_o(pop),
    .rsp_valid_o(done_o), .rsp_o(rsp_o), .idle_o(idle)
  );

  // Scan results never flag overflow.
  a_scan_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.scan_done |-> !rsp_o.table_overflow) else $error("ovf on scan");
  // An empty range is never reported.
  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.range_valid |-> rsp_o.range_start != rsp_o.range_end)
    else $error("empty range");
  // The engine never pops an empty queue.
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !empty)
    else $error("pop empty");
  // An idle engine has nothing queued.
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni) idle |-> empty)
    else $error("idle mismatch");

endmodule

// ----- sv/haurf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transaction queue
// Two-entry queue between the front end and the table engine.
// ----------------------------------------------------------------------------
module haurf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  haurf_pkg::req_t   push_data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output haurf_pkg::req_t   pop_data_o
);

  haurf_pkg::req_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  // Pointer and fill count update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // Payload storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

  assign full_o     = cnt_q[1];
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rptr_q];

endmodule

// ----- sv/haurf_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table engine
// Probes the keyed count table one slot at a time (read, then compare),
// updates counts and the anchor, and produces one result per transaction.
// ----------------------------------------------------------------------------
module haurf_engine #(
  parameter int unsigned TableEntries = haurf_pkg::TableEntriesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  haurf_pkg::req_t req_i,
  output logic            req_pop_o,
  output logic            rsp_valid_o,
  output haurf_pkg::rsp_t rsp_o,
  output logic            idle_o
);

  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned EpW  = 8;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StWrite = 3'd3;
  localparam logic [2:0] StClear = 3'd4;

  // Memories: key, count and epoch stamp; an entry is valid when its
  // stamp matches the current epoch, so a last scan chunk clears by bumping it.
  logic [31:0]                key_mem [TableEntries];
  logic [haurf_pkg::CountW-1:0] cnt_mem [TableEntries];
  logic [EpW-1:0]             ep_mem  [TableEntries];

  logic [2:0]   state_q, state_d;
  haurf_pkg::req_t cur_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW:0]   steps_q, steps_d;
  logic [EpW-1:0]  epoch_q;
  logic [IdxW:0]   clr_q;
  logic [31:0]     rd_key_q;
  logic [haurf_pkg::CountW-1:0] rd_cnt_q;
  logic [EpW-1:0]  rd_ep_q;
  logic [31:0]     anc_end_q, anc_hash_q;
  logic            rsp_valid_q;
  haurf_pkg::rsp_t rsp_q, rsp_d;

  logic            wr_en;
  logic [31:0]     wr_key;
  logic [haurf_pkg::CountW-1:0] wr_cnt;
  logic            slot_valid, hit;
  logic            common, last_scan, clr_last;
  logic [31:0]     close_pt;

  assign slot_valid = (rd_ep_q == epoch_q);
  assign hit        = slot_valid && (rd_key_q == cur_q.chunk_hash);
  assign common     = hit && (rd_cnt_q != '0);
  assign last_scan  = (cur_q.action == haurf_pkg::ActScan) && cur_q.last_chunk;
  assign clr_last   = (clr_q == (IdxW+1)'(TableEntries - 1));
  assign close_pt   = (common || !cur_q.last_chunk) ? cur_q.chunk_start : cur_q.chunk_end;

  // Memory read and write ports; the sweep stamps every slot with the
  // current epoch, which the end of the sweep leaves behind.
  always_ff @(posedge clk_i) begin
    rd_key_q <= key_mem[idx_q];
    rd_cnt_q <= cnt_mem[idx_q];
    rd_ep_q  <= ep_mem[idx_q];
    if (wr_en) begin
      key_mem[idx_q] <= wr_key;
      cnt_mem[idx_q] <= wr_cnt;
      ep_mem[idx_q]  <= epoch_q;
    end else if (state_q == StClear) begin
      ep_mem[clr_q[IdxW-1:0]] <= epoch_q;
    end
  end

  // Probe sequencer.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    steps_d = steps_q;
    wr_en   = 1'b0;
    wr_key  = cur_q.chunk_hash;
    wr_cnt  = rd_cnt_q;
    unique case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          state_d = StRead;
          idx_d   = req_i.chunk_hash[IdxW-1:0];
          steps_d = '0;
        end
      end
      StRead:  state_d = StCheck;
      StCheck: begin
        if (!slot_valid || hit || steps_q == (IdxW+1)'(TableEntries - 1)) begin
          state_d = StWrite;
        end else begin
          idx_d   = idx_q + 1'b1;
          steps_d = steps_q + 1'b1;
          state_d = StRead;
        end
      end
      StWrite: begin
        // Stale stamps could alias after the epoch wraps; resweep then.
        state_d = (last_scan && epoch_q == 8'hFE) ? StClear : StIdle;
        if (cur_q.action == haurf_pkg::ActCount) begin
          if (hit) begin
            wr_en  = (rd_cnt_q != haurf_pkg::CountMax);
            wr_cnt = rd_cnt_q + 1'b1;
          end else if (!slot_valid) begin
            wr_en  = 1'b1;
            wr_cnt = haurf_pkg::CountW'(1);
          end
        end else if (hit && rd_cnt_q != '0) begin
          wr_en  = 1'b1;
          wr_cnt = rd_cnt_q - 1'b1;
        end
      end
      StClear: state_d = clr_last ? StIdle : StClear;
      default: state_d = StIdle;
    endcase
  end

  // Result formation on the write step.
  always_comb begin
    rsp_d = '0;
    if (cur_q.action == haurf_pkg::ActCount) begin
      rsp_d.table_overflow = hit ? (rd_cnt_q == haurf_pkg::CountMax) : slot_valid;
    end else begin
      if ((cur_q.last_chunk || common) && close_pt != anc_end_q) begin
        rsp_d.range_valid = 1'b1;
        rsp_d.range_start = anc_end_q;
        rsp_d.range_end   = close_pt;
        rsp_d.anchor_tag  = anc_hash_q;
      end
      rsp_d.scan_done = cur_q.last_chunk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      idx_q       <= '0;
      steps_q     <= '0;
      epoch_q     <= '1;
      clr_q       <= '0;
      anc_end_q   <= '0;
      anc_hash_q  <= '0;
      rsp_valid_q <= 1'b0;
      cur_q       <= '0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      steps_q     <= steps_d;
      rsp_valid_q <= (state_q == StWrite);
      // Sweep counter runs only while sweeping.
      clr_q       <= (state_q == StClear) ? clr_q + 1'b1 : '0;
      if (state_q == StIdle && req_valid_i) cur_q <= req_i;
      if (state_q == StWrite) rsp_q <= rsp_d;
      // A new epoch starts after a sweep and after every last scan chunk.
      if ((state_q == StClear && clr_last) || (state_q == StWrite && last_scan)) begin
        epoch_q <= epoch_q + 8'd1;
      end
      // Anchor update.
      if (state_q == StWrite && cur_q.action == haurf_pkg::ActScan) begin
        if (cur_q.last_chunk) begin
          anc_end_q  <= '0;
          anc_hash_q <= '0;
        end else if (common) begin
          anc_end_q  <= cur_q.chunk_end;
          anc_hash_q <= cur_q.chunk_hash;
        end
      end
    end
  end

  assign req_pop_o   = (state_q == StIdle) && req_valid_i;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign idle_o      = (state_q == StIdle) && !req_valid_i;

endmodule

// ----- dv/hash_anchored_unique_range_finder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unique range finder testbench
// Drives count and scan transactions into the range finder, predicts each
// response with a local model of the hash table and anchor, and checks every
// response field by field against the oldest prediction.
// ----------------------------------------------------------------------------

// Holds the predicted responses and compares the block's output against them.
class range_scoreboard;
  haurf_pkg::rsp_t pending_rsp[$];
  int unsigned     mismatch_cnt;

  // Notes a predicted response for an accepted transaction.
  function void note_request(haurf_pkg::rsp_t predicted);
    pending_rsp.push_back(predicted);
  endfunction

  // Compares one response with the oldest prediction.
  function void check_response(haurf_pkg::rsp_t actual);
    haurf_pkg::rsp_t want;
    if (pending_rsp.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("Unexpected response %h", actual);
      return;
    end
    want = pending_rsp.pop_front();
    if (actual !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("Mismatch: valid %0b/%0b start %h/%h end %h/%h",
                 want.range_valid, actual.range_valid, want.range_start,
                 actual.range_start, want.range_end, actual.range_end);
        $display("  tag %h/%h done %0b/%0b overflow %0b/%0b",
                 want.anchor_tag, actual.anchor_tag, want.scan_done,
                 actual.scan_done, want.table_overflow, actual.table_overflow);
      end
    end
  endfunction
endclass

module hash_anchored_unique_range_finder_tb;

  localparam int unsigned Slots = haurf_pkg::TableEntriesDef;
  localparam int unsigned CycleLimit = 1_500_000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  haurf_pkg::req_t req_i;
  logic done_o;
  haurf_pkg::rsp_t rsp_o;

  // Local copy of the table and anchor.
  logic [31:0]     slot_key[Slots];
  logic [haurf_pkg::CountW-1:0] slot_count[Slots];
  bit              slot_used[Slots];
  logic [31:0]     anc_end;
  logic [31:0]     anc_hash;

  // Hashes counted in the current pass, used to build common chunks.
  logic [31:0]     other_hashes[$];
  int unsigned     cycle_cnt = 0;
  int unsigned     sent_cnt = 0;
  range_scoreboard board;

  hash_anchored_unique_range_finder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Clears the predicted table and anchor.
  function automatic void clear_model();
    for (int i = 0; i < Slots; i++) slot_used[i] = 1'b0;
    anc_end  = '0;
    anc_hash = '0;
  endfunction

  // Linear probe: returns 1 and the slot on a hit, else the first free slot.
  function automatic bit find_slot(logic [31:0] key, output int slot,
                                   output bit has_free);
    int idx;
    slot = 0;
    has_free = 1'b0;
    for (int i = 0; i < Slots; i++) begin
      idx = (key % Slots + i) % Slots;
      if (!slot_used[idx]) begin
        slot = idx;
        has_free = 1'b1;
        return 1'b0;
      end
      if (slot_key[idx] == key) begin
        slot = idx;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Works out the response of one transaction and advances the local state.
  function automatic haurf_pkg::rsp_t predict_range(haurf_pkg::req_t r);
    haurf_pkg::rsp_t p;
    int    slot;
    bit    has_free;
    bit    hit;
    bit    common;
    logic [31:0] close;
    p = '0;
    hit = find_slot(r.chunk_hash, slot, has_free);
    if (r.action == haurf_pkg::ActCount) begin
      if (hit) begin
        if (slot_count[slot] == haurf_pkg::CountMax) p.table_overflow = 1'b1;
        else slot_count[slot] = slot_count[slot] + 1'b1;
      end else if (!has_free) begin
        p.table_overflow = 1'b1;
      end else begin
        slot_used[slot]  = 1'b1;
        slot_key[slot]   = r.chunk_hash;
        slot_count[slot] = haurf_pkg::CountW'(1);
      end
    end else begin
      common = hit && slot_count[slot] != 0;
      if (common) slot_count[slot] = slot_count[slot] - 1'b1;
      if (r.last_chunk) begin
        close = common ? r.chunk_start : r.chunk_end;
        if (close != anc_end) begin
          p.range_valid = 1'b1;
          p.range_start = anc_end;
          p.range_end   = close;
          p.anchor_tag  = anc_hash;
        end
        p.scan_done = 1'b1;
        clear_model();
      end else if (common) begin
        if (r.chunk_start != anc_end) begin
          p.range_valid = 1'b1;
          p.range_start = anc_end;
          p.range_end   = r.chunk_start;
          p.anchor_tag  = anc_hash;
        end
        anc_end  = r.chunk_end;
        anc_hash = r.chunk_hash;
      end
    end
    return p;
  endfunction

  // Random pause of the sender; short bursts most of the time.
  int unsigned burst_left;
  task automatic sender_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // Presents one transaction and waits until the block takes it; start
  // stays high until a gap or a drain lowers it.
  task automatic send_item(haurf_pkg::req_t r);
    sender_gap();
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    board.note_request(predict_range(r));
    sent_cnt++;
  endtask

  task automatic send_count(logic [31:0] h, logic lst = 1'b0);
    haurf_pkg::req_t r;
    r = '0;
    r.action = haurf_pkg::ActCount;
    r.chunk_hash = h;
    r.last_chunk = lst;
    r.chunk_start = $urandom();
    r.chunk_end = $urandom();
    send_item(r);
  endtask

  task automatic send_scan(logic [31:0] s, logic [31:0] e, logic [31:0] h,
                           logic lst);
    haurf_pkg::req_t r;
    r.action = haurf_pkg::ActScan;
    r.chunk_start = s;
    r.chunk_end = e;
    r.chunk_hash = h;
    r.last_chunk = lst;
    send_item(r);
  endtask

  // Waits until every predicted response has arrived, then a little more.
  task automatic drain();
    start <= 1'b0;
    while (board.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Picks a hash from a small pool so that collisions and repeats happen.
  function automatic logic [31:0] pool_hash();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 40);
      2: return (32'($urandom_range(0, 7)) << 24) | 32'(Slots * $urandom_range(0, 3));
      default: return 32'hFFFF_FF00 | $urandom_range(0, 255);
    endcase
  endfunction

  // One well formed pass: count the other stream, then scan ours.
  task automatic random_pass(int unsigned n_their, int unsigned n_ours);
    logic [31:0] pos;
    logic [31:0] len;
    logic [31:0] h;
    other_hashes = {};
    for (int i = 0; i < n_their; i++) begin
      h = pool_hash();
      other_hashes.push_back(h);
      send_count(h, 1'($urandom_range(0, 1)));
    end
    pos = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 3);
    for (int i = 0; i < n_ours; i++) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 600);
      if (other_hashes.size() != 0 && $urandom_range(0, 2) != 0)
        h = other_hashes[$urandom_range(0, other_hashes.size() - 1)];
      else h = pool_hash();
      if ($urandom_range(0, 9) == 0) send_scan($urandom(), $urandom(), h, 1'b0);
      else send_scan(pos, pos + len, h, 1'b0);
      if ($urandom_range(0, 4) == 0) pos = pos + len + $urandom_range(1, 50);
      else pos = pos + len;
    end
    h = (other_hashes.size() != 0 && $urandom_range(0, 1) != 0) ?
        other_hashes[0] : pool_hash();
    send_scan(pos, pos + $urandom_range(0, 100), h, 1'b1);
  endtask

  // Response checking and run limit.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) board.check_response(rsp_o);
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("hash_anchored_unique_range_finder_tb failed");
      $finish;
    end
  end

  initial begin
    board = new();
    clear_model();
    burst_left = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: common chunks with and without gaps, extremes, last on count.
    send_count(32'h0000_0000);
    send_count(32'hFFFF_FFFF, 1'b1);
    send_count(32'h0000_0100);
    send_count(32'h0000_0100);
    send_scan(32'h0, 32'h10, 32'h0, 1'b0);
    send_scan(32'h20, 32'h30, 32'h100, 1'b0);
    send_scan(32'h30, 32'h40, 32'h100, 1'b0);
    send_scan(32'h40, 32'h50, 32'h100, 1'b0);
    send_scan(32'hFFFF_FFFF, 32'h5, 32'hFFFF_FFFF, 1'b0);
    send_scan(32'h5, 32'hFFFF_FFFF, 32'h1234, 1'b1);
    // Last chunk common, closing at its start; then empty final gap.
    send_count(32'hABCD_0001);
    send_scan(32'h0, 32'h8, 32'hABCD_0001, 1'b1);
    send_scan(32'h0, 32'h0, 32'h7, 1'b1);
    drain();

    // Table full: fill every slot, then one more key overflows.
    for (int i = 0; i < Slots; i++) send_count(i * 3 + 32'h8000_0000);
    send_count(32'h1234_5678);
    send_scan(32'h0, 32'h4, 32'h8000_0000, 1'b1);
    // Full sender pause until every response has come.
    drain();

    // Random passes.
    while (sent_cnt < 450) begin
      int unsigned nt;
      int unsigned no;
      nt = $urandom_range(0, 20);
      no = $urandom_range(1, 20);
      if ($urandom_range(0, 9) == 0) nt = $urandom_range(40, 80);
      random_pass(nt, no);
    end

    drain();
    repeat (30) @(posedge clk_i);
    if (board.mismatch_cnt == 0) begin
      $display("hash_anchored_unique_range_finder_tb passed");
    end else begin
      $display("hash_anchored_unique_range_finder_tb failed");
    end
    $finish;
  end

endmodule
